// ----- rtl/fea_pkg.sv -----
// ----------------------------------------------------------------------------
// Free extent allocator package
// Shared widths, table entry type, cell operations and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fea_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int OFFSET_BITS   = 24;
    localparam int SIZE_W        = OFFSET_BITS + 1;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCK = CFG_IDX_W'(1);

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [SIZE_W-1:0]      length;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_CLEAR
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_FIT    = 3'd3,
        ST_OUTSIDE   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/free_extent_allocator.sv -----
// ----------------------------------------------------------------------------
// Free extent allocator
// Best-fit allocator over a row of extent cells kept sorted by offset.
// ----------------------------------------------------------------------------
// Rejected requests and releases at offset zero are answered without a scan;
// other requests scan the table, reading one entry per cycle.
// Requests are taken one at a time; a new one is accepted once the result
// is registered on the output, unless a configuration write is pending.
// Reset: the table holds one extent covering the 16 MiB pool, both
// configuration registers read 16777216 and no result is pending.
`default_nettype none

module free_extent_allocator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              mode,
    input  wire logic [fea_pkg::SIZE_W-1:0]        block_size,
    input  wire logic [fea_pkg::OFFSET_BITS-1:0]   block_offset,
    input  wire logic [3:0]                        align_log2,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [2:0]                             status,
    output logic [fea_pkg::OFFSET_BITS-1:0]        granted_offset,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fea_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fea_pkg::SIZE_W-1:0]        cfg_data
);
    import fea_pkg::*;

    localparam logic [SIZE_W-1:0] POOL_CAP = SIZE_W'(1) << OFFSET_BITS;
    localparam int                R_W      = SIZE_W + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_PEEK  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   mode_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [R_W-1:0]         r_reg, r_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    entry_t                 prev_reg;
    logic                   found_reg, found_next;
    logic [SIZE_W-1:0]      best_len_reg, best_len_next;
    logic [OFFSET_BITS-1:0] best_start_reg, best_start_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic                   ins_found_reg, ins_found_next;
    logic [IDX_W-1:0]       ins_idx_reg, ins_idx_next;
    logic                   gt0_reg, gt0_next;
    logic [R_W-1:0]         lsum_reg, lsum_next;
    logic [OFFSET_BITS-1:0] bst_reg, bst_next;
    status_t                res_status_reg, res_status_next;
    logic [OFFSET_BITS-1:0] res_grant_reg, res_grant_next;
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             status_reg, status_next;
    logic [OFFSET_BITS-1:0] grant_reg, grant_next;
    logic [SIZE_W-1:0]      pool_reg, pool_next;
    logic [SIZE_W-1:0]      maxb_reg, maxb_next;

    entry_t                 cells [TABLE_ENTRIES];
    cell_op_t               ops [TABLE_ENTRIES];
    entry_t                 load_data;
    logic                   ld_en, rm_en, ins_en, clear_all;
    logic [IDX_W-1:0]       ld_idx, rm_idx, ins_idx;

    logic                   in_acc, cfg_acc;
    logic [SIZE_W-1:0]      usable, cfg_usable, lim;
    logic [R_W-1:0]         mask, r_calc;
    logic [IDX_W-1:0]       rd_idx;
    entry_t                 cur;
    logic [R_W-1:0]         offsize;
    logic [SIZE_W-1:0]      cur_end, prev_end;
    logic [R_W:0]           peek_end;

    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign usable     = (pool_reg > POOL_CAP) ? POOL_CAP : pool_reg;
    assign cfg_usable = (cfg_data > POOL_CAP) ? POOL_CAP : cfg_data;
    assign lim        = (maxb_reg < usable) ? maxb_reg : usable;

    assign mask   = (R_W'(1) << align_log2) - R_W'(1);
    assign r_calc = ({1'b0, block_size} + mask) & ~mask;

    assign rd_idx   = (state_reg == S_PEEK) ? IDX_W'(k_reg + CNT_W'(1)) : k_reg[IDX_W-1:0];
    assign cur      = cells[rd_idx];
    assign offsize  = {2'b00, off_reg} + {1'b0, size_reg};
    assign cur_end  = {1'b0, cur.start} + cur.length;
    assign prev_end = {1'b0, prev_reg.start} + prev_reg.length;
    assign peek_end = {2'b00, bst_reg} + {1'b0, lsum_reg};

    always_comb
    begin
        state_next      = state_reg;
        r_next          = r_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        best_idx_next   = best_idx_reg;
        ins_found_next  = ins_found_reg;
        ins_idx_next    = ins_idx_reg;
        gt0_next        = gt0_reg;
        lsum_next       = lsum_reg;
        bst_next        = bst_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        pool_next       = pool_reg;
        maxb_next       = maxb_reg;
        load_data       = '0;
        ld_en           = 1'b0;
        ld_idx          = '0;
        rm_en           = 1'b0;
        rm_idx          = '0;
        ins_en          = 1'b0;
        ins_idx         = '0;
        clear_all       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_acc)
                begin
                    if (cfg_index == CFG_POOL_SIZE)
                    begin
                        pool_next       = cfg_data;
                        clear_all       = 1'b1;
                        load_data.start = '0;
                        load_data.length = cfg_usable;
                        count_next      = CNT_W'(cfg_usable != '0);
                    end
                    else if (cfg_index == CFG_MAX_BLOCK)
                    begin
                        maxb_next = cfg_data;
                    end
                end
                else if (in_acc)
                begin
                    r_next     = r_calc;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                k_next         = '0;
                found_next     = 1'b0;
                ins_found_next = 1'b0;
                gt0_next       = 1'b0;
                res_grant_next = '0;
                res_status_next = ST_OK;
                state_next     = S_RESP;
                if (!mode_reg)
                begin
                    if (r_reg == '0)
                        res_status_next = ST_ZERO_SIZE;
                    else if (r_reg > {1'b0, lim})
                        res_status_next = ST_TOO_LARGE;
                    else if (count_reg == '0)
                        res_status_next = ST_NO_FIT;
                    else
                        state_next = S_SCAN;
                end
                else
                begin
                    if (size_reg == '0)
                        res_status_next = ST_ZERO_SIZE;
                    else if (offsize > {1'b0, usable})
                        res_status_next = ST_OUTSIDE;
                    else if (off_reg == '0)
                    begin
                        if (count_reg != '0 && {1'b0, cells[0].start} == size_reg)
                        begin
                            ld_en            = 1'b1;
                            ld_idx           = '0;
                            load_data.start  = '0;
                            load_data.length = cells[0].length + size_reg;
                        end
                        else if (count_reg == CNT_W'(TABLE_ENTRIES))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            ins_en           = 1'b1;
                            ins_idx          = '0;
                            ld_en            = 1'b1;
                            ld_idx           = '0;
                            load_data.start  = '0;
                            load_data.length = size_reg;
                            count_next       = count_reg + CNT_W'(1);
                        end
                    end
                    else
                        state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg < count_reg)
                begin
                    if (!mode_reg)
                    begin
                        if ({1'b0, cur.length} == r_reg)
                        begin
                            res_grant_next = cur.start;
                            rm_en          = 1'b1;
                            rm_idx         = k_reg[IDX_W-1:0];
                            count_next     = count_reg - CNT_W'(1);
                            state_next     = S_RESP;
                        end
                        else if ({1'b0, cur.length} > r_reg
                                 && (!found_reg || cur.length < best_len_reg))
                        begin
                            found_next      = 1'b1;
                            best_len_next   = cur.length;
                            best_start_next = cur.start;
                            best_idx_next   = k_reg[IDX_W-1:0];
                        end
                    end
                    else
                    begin
                        if (offsize == {2'b00, cur.start})
                        begin
                            state_next = S_RESP;
                            if (k_reg != '0 && prev_end == {1'b0, off_reg})
                            begin
                                ld_en            = 1'b1;
                                ld_idx           = IDX_W'(k_reg - CNT_W'(1));
                                load_data.start  = prev_reg.start;
                                load_data.length = SIZE_W'(prev_reg.length + size_reg
                                                           + cur.length);
                                rm_en            = 1'b1;
                                rm_idx           = k_reg[IDX_W-1:0];
                                count_next       = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                ld_en            = 1'b1;
                                ld_idx           = k_reg[IDX_W-1:0];
                                load_data.start  = off_reg;
                                load_data.length = cur.length + size_reg;
                            end
                        end
                        else if (cur_end == {1'b0, off_reg})
                        begin
                            if (k_reg + CNT_W'(1) < count_reg)
                            begin
                                k_next     = k_reg;
                                bst_next   = cur.start;
                                lsum_next  = {1'b0, cur.length} + {1'b0, size_reg};
                                state_next = S_PEEK;
                            end
                            else
                            begin
                                ld_en            = 1'b1;
                                ld_idx           = k_reg[IDX_W-1:0];
                                load_data.start  = cur.start;
                                load_data.length = cur.length + size_reg;
                                state_next       = S_RESP;
                            end
                        end
                        else
                        begin
                            if (k_reg == '0)
                                gt0_next = cur.start > off_reg;
                            if (k_reg != '0 && !ins_found_reg && cur.start >= off_reg)
                            begin
                                ins_found_next = 1'b1;
                                ins_idx_next   = k_reg[IDX_W-1:0];
                            end
                        end
                    end
                end
                else
                begin
                    state_next = S_RESP;
                    if (!mode_reg)
                    begin
                        if (found_reg)
                        begin
                            res_grant_next   = best_start_reg;
                            ld_en            = 1'b1;
                            ld_idx           = best_idx_reg;
                            load_data.start  = OFFSET_BITS'(best_start_reg + r_reg);
                            load_data.length = SIZE_W'(best_len_reg - r_reg);
                        end
                        else
                            res_status_next = ST_NO_FIT;
                    end
                    else if (count_reg == CNT_W'(TABLE_ENTRIES))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ins_en = 1'b1;
                        if (count_reg == '0 || gt0_reg)
                            ins_idx = '0;
                        else if (ins_found_reg)
                            ins_idx = ins_idx_reg;
                        else
                            ins_idx = count_reg[IDX_W-1:0];
                        ld_en            = 1'b1;
                        ld_idx           = ins_idx;
                        load_data.start  = off_reg;
                        load_data.length = size_reg;
                        count_next       = count_reg + CNT_W'(1);
                    end
                end
            end

            S_PEEK:
            begin
                state_next      = S_RESP;
                ld_en           = 1'b1;
                ld_idx          = k_reg[IDX_W-1:0];
                load_data.start = bst_reg;
                if (peek_end == {3'b000, cur.start})
                begin
                    load_data.length = SIZE_W'(lsum_reg + {1'b0, cur.length});
                    rm_en            = 1'b1;
                    rm_idx           = IDX_W'(k_reg + CNT_W'(1));
                    count_next       = count_reg - CNT_W'(1);
                end
                else
                    load_data.length = SIZE_W'(lsum_reg);
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        grant_next     = grant_reg;
        if (state_reg == S_RESP && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            status_next    = res_status_reg;
            grant_next     = (res_status_reg == ST_OK) ? res_grant_reg : '0;
        end
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        entry_t left_e, right_e, init_e;

        if (i == 0)
        begin : g_first
            assign left_e       = '0;
            assign init_e.start = '0;
            assign init_e.length = POOL_CAP;
        end
        else
        begin : g_rest
            assign left_e = cells[i-1];
            assign init_e = '0;
        end

        if (i == TABLE_ENTRIES - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_mid
            assign right_e = cells[i+1];
        end

        always_comb
        begin
            priority if (clear_all)
                ops[i] = (i == 0) ? CELL_LOAD : CELL_CLEAR;
            else if (rm_en && IDX_W'(i) >= rm_idx)
                ops[i] = CELL_FROM_RIGHT;
            else if (ins_en && IDX_W'(i) > ins_idx)
                ops[i] = CELL_FROM_LEFT;
            else if (ld_en && IDX_W'(i) == ld_idx)
                ops[i] = CELL_LOAD;
            else
                ops[i] = CELL_HOLD;
        end

        fea_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .init_entry  (init_e),
            .op          (ops[i]),
            .load_data   (load_data),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cells[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            pool_reg      <= POOL_CAP;
            maxb_reg      <= POOL_CAP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pool_reg      <= pool_next;
            maxb_reg      <= maxb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg <= mode;
            size_reg <= block_size;
            off_reg  <= block_offset;
        end
        if (state_reg == S_SCAN)
            prev_reg <= cur;
        r_reg          <= r_next;
        k_reg          <= k_next;
        found_reg      <= found_next;
        best_len_reg   <= best_len_next;
        best_start_reg <= best_start_next;
        best_idx_reg   <= best_idx_next;
        ins_found_reg  <= ins_found_next;
        ins_idx_reg    <= ins_idx_next;
        gt0_reg        <= gt0_next;
        lsum_reg       <= lsum_next;
        bst_reg        <= bst_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        status_reg     <= status_next;
        grant_reg      <= grant_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_offset = grant_reg;

endmodule

`default_nettype wire

// ----- rtl/fea_cell.sv -----
// ----------------------------------------------------------------------------
// Free extent table cell
// Holds one extent and takes a new value, a neighbor's extent or zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fea_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fea_pkg::entry_t   init_entry,
    input  wire fea_pkg::cell_op_t op,
    input  wire fea_pkg::entry_t   load_data,
    input  wire fea_pkg::entry_t   left_entry,
    input  wire fea_pkg::entry_t   right_entry,
    output fea_pkg::entry_t        entry
);
    import fea_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        unique case (op)
            CELL_HOLD:       entry_next = entry_reg;
            CELL_LOAD:       entry_next = load_data;
            CELL_FROM_LEFT:  entry_next = left_entry;
            CELL_FROM_RIGHT: entry_next = right_entry;
            CELL_CLEAR:      entry_next = '0;
            default:         entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= init_entry;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
